// ===== src/lzw_pkg.sv =====
// ----------------------------------------------------------------------------
// LZW encoder package
// Shared widths, the search token, the write bundle and the state type of the
// 12-bit LZW encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lzw_pkg;

  localparam int BYTE_W   = 8;
  localparam int CODE_W   = 12;
  localparam int NFC_W    = 13;
  localparam int ENTRY_W  = CODE_W + BYTE_W;
  localparam int ALPHABET = 256;
  localparam int CODE_MAX = 4096;

  // A search token walks the cell row, one cell per cycle.
  typedef struct packed {
    logic              active;
    logic              last;
    logic              hit;
    logic [CODE_W-1:0] row;
    logic [CODE_W-1:0] code;
  } lzw_tok_t;

  // A dictionary write, broadcast to every cell.
  typedef struct packed {
    logic               en;
    logic [CODE_W-1:0]  code;
    logic [ENTRY_W-1:0] data;
  } lzw_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MISS,
    ST_FLUSH
  } lzw_state_t;

endpackage

`default_nettype wire

// ===== src/lzw_if.sv =====
// ----------------------------------------------------------------------------
// LZW encoder channels
// Valid/ready channels for input bytes and emitted codes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzw_in_if;
  logic                      valid;
  logic                      ready;
  logic [lzw_pkg::BYTE_W-1:0] data_byte;
  logic                      end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface lzw_out_if;
  logic                      valid;
  logic                      ready;
  logic [lzw_pkg::CODE_W-1:0] code;
  logic                      last_code;

  modport source (output valid, output code, output last_code, input ready);
  modport sink   (input valid, input code, input last_code, output ready);
endinterface

`default_nettype wire

// ===== src/lzw_cell.sv =====
// ----------------------------------------------------------------------------
// LZW dictionary cell
// Holds every entry whose code maps to this cell and checks a passing search
// token against its entry for the token's row.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_cell #(
  parameter int NUM_CELLS = 8,
  parameter int CELL_IDX  = 0,
  parameter int ROWS      = 512
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lzw_pkg::lzw_tok_t             tok_i,
  output lzw_pkg::lzw_tok_t                  tok_o,
  input  wire logic [lzw_pkg::ENTRY_W-1:0]   key_i,
  input  wire logic [lzw_pkg::NFC_W-1:0]     nfc_i,
  input  wire lzw_pkg::lzw_wr_t              wr_i
);

  localparam int CELL_W = $clog2(NUM_CELLS);
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [CELL_W-1:0] IDX = CELL_W'(CELL_IDX);

  logic [lzw_pkg::ENTRY_W-1:0] mem [ROWS];
  logic [lzw_pkg::ENTRY_W-1:0] rd_r;
  lzw_pkg::lzw_tok_t           tok_r;
  logic [lzw_pkg::CODE_W-1:0]  own_code;
  logic                        match;

  always_ff @(posedge clk) begin
    if (wr_i.en && (wr_i.code[CELL_W-1:0] == IDX)) begin
      mem[wr_i.code[CELL_W +: ROW_W]] <= wr_i.data;
    end
    rd_r <= mem[tok_i.row[ROW_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
    end else begin
      tok_r <= tok_i;
    end
  end

  // The entry is live only if its code lies below the next free code.
  assign own_code = lzw_pkg::CODE_W'({tok_r.row[ROW_W-1:0], IDX});
  assign match    = tok_r.active && (rd_r == key_i) && ({1'b0, own_code} < nfc_i);

  always_comb begin
    tok_o = tok_r;
    if (match) begin
      tok_o.hit  = 1'b1;
      tok_o.code = own_code;
    end
  end

endmodule

`default_nettype wire

// ===== src/lzw_encoder_top.sv =====
// ----------------------------------------------------------------------------
// LZW encoder top level
// 12-bit LZW compression encoder built on a row of dictionary search cells.
// ----------------------------------------------------------------------------
// Usage: bytes arrive on in_ch, one per beat, with end_of_input set on the
// last byte of a stream. Codes leave on out_ch, one per beat; last_code marks
// the final code of a stream, after which the dictionary starts empty again.
// The dictionary is spread over NUM_CELLS cells: code c lives in cell
// c mod NUM_CELLS at row c / NUM_CELLS. A lookup sends one token per row into
// the cell row, one row per cycle, and each token checks one entry per cell
// as it moves along. A byte that only starts a prefix, or arrives while the
// dictionary is still empty, needs no lookup; any other byte scans the R
// occupied rows, where R is (next_free_code - 256) / NUM_CELLS rounded up;
// this scan through the cell row sets the rate. A miss or a flush moves its
// code into the output register from its own state. Reset (synchronous,
// active low) empties the dictionary and clears the prefix; no clearing
// pass is needed since only entries below the next free code can match.
// When the receiver stalls, one code waits in the output register; bytes are
// still taken, but a miss or flush waits until that code has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_encoder_top #(
  parameter int DICT_ENTRIES = 4096,
  parameter int NUM_CELLS    = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lzw_in_if.sink    in_ch,
  lzw_out_if.source out_ch
);

  localparam int CODE_LIMIT = (DICT_ENTRIES < lzw_pkg::CODE_MAX) ? DICT_ENTRIES
                                                                  : lzw_pkg::CODE_MAX;
  localparam int CELL_W     = $clog2(NUM_CELLS);
  localparam int ROWS       = (CODE_LIMIT + NUM_CELLS - 1) / NUM_CELLS;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FIRST_ROW  = lzw_pkg::ALPHABET / NUM_CELLS;

  localparam logic [lzw_pkg::NFC_W-1:0] NFC_START = lzw_pkg::NFC_W'(lzw_pkg::ALPHABET);
  localparam logic [lzw_pkg::NFC_W-1:0] NFC_LIMIT = lzw_pkg::NFC_W'(CODE_LIMIT);

  lzw_pkg::lzw_state_t state_r, state_nxt;

  logic [lzw_pkg::BYTE_W-1:0]  byte_r;
  logic                        last_r;
  logic [lzw_pkg::CODE_W-1:0]  prefix_r;
  logic                        pv_r;
  logic [lzw_pkg::NFC_W-1:0]   nfc_r;
  logic [lzw_pkg::NFC_W-1:0]   nfc_m1;
  logic [lzw_pkg::ENTRY_W-1:0] key_r;
  logic [ROW_W-1:0]            row_r;
  logic [ROW_W-1:0]            last_row_r;
  logic                        issuing_r;
  logic                        hit_r;
  logic [lzw_pkg::CODE_W-1:0]  hit_code_r;
  logic                        out_valid_r;
  logic [lzw_pkg::CODE_W-1:0]  out_code_r;
  logic                        out_last_r;

  logic accept, out_free, load_miss, load_flush, scan_done, found;

  lzw_pkg::lzw_tok_t tok [NUM_CELLS+1];
  lzw_pkg::lzw_wr_t  wr;

  // Issue one token per occupied row; the tail row token carries the last flag.
  always_comb begin
    tok[0].active = (state_r == lzw_pkg::ST_SCAN) && issuing_r;
    tok[0].last   = (row_r == last_row_r);
    tok[0].hit    = 1'b0;
    tok[0].row    = lzw_pkg::CODE_W'(row_r);
    tok[0].code   = '0;
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    lzw_cell #(
      .NUM_CELLS (NUM_CELLS),
      .CELL_IDX  (i),
      .ROWS      (ROWS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok[i]),
      .tok_o (tok[i+1]),
      .key_i (key_r),
      .nfc_i (nfc_r),
      .wr_i  (wr)
    );
  end

  assign nfc_m1 = nfc_r - lzw_pkg::NFC_W'(1);
  assign found  = hit_r || tok[NUM_CELLS].hit;

  // Control strobes.
  always_comb begin
    out_free   = !out_valid_r || out_ch.ready;
    in_ch.ready = (state_r == lzw_pkg::ST_IDLE);
    accept     = in_ch.valid && (state_r == lzw_pkg::ST_IDLE);
    load_miss  = (state_r == lzw_pkg::ST_MISS) && out_free;
    load_flush = (state_r == lzw_pkg::ST_FLUSH) && out_free;
    scan_done  = (state_r == lzw_pkg::ST_SCAN) && tok[NUM_CELLS].active &&
                 tok[NUM_CELLS].last;
    wr.en      = load_miss && (nfc_r < NFC_LIMIT);
    wr.code    = nfc_r[lzw_pkg::CODE_W-1:0];
    wr.data    = {prefix_r, byte_r};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lzw_pkg::ST_IDLE: begin
        if (accept) begin
          if (!pv_r) begin
            state_nxt = in_ch.end_of_input ? lzw_pkg::ST_FLUSH : lzw_pkg::ST_IDLE;
          end else if (nfc_r == NFC_START) begin
            state_nxt = lzw_pkg::ST_MISS;
          end else begin
            state_nxt = lzw_pkg::ST_SCAN;
          end
        end
      end
      lzw_pkg::ST_SCAN: begin
        if (scan_done) begin
          if (found) begin
            state_nxt = last_r ? lzw_pkg::ST_FLUSH : lzw_pkg::ST_IDLE;
          end else begin
            state_nxt = lzw_pkg::ST_MISS;
          end
        end
      end
      lzw_pkg::ST_MISS: begin
        if (out_free) begin
          state_nxt = last_r ? lzw_pkg::ST_FLUSH : lzw_pkg::ST_IDLE;
        end
      end
      lzw_pkg::ST_FLUSH: begin
        if (out_free) begin
          state_nxt = lzw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lzw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Stream state and search control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r      <= 1'b0;
      prefix_r  <= '0;
      nfc_r     <= NFC_START;
      issuing_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      if (accept) begin
        byte_r     <= in_ch.data_byte;
        last_r     <= in_ch.end_of_input;
        key_r      <= {prefix_r, in_ch.data_byte};
        row_r      <= ROW_W'(FIRST_ROW);
        last_row_r <= ROW_W'(nfc_m1 >> CELL_W);
        hit_r      <= 1'b0;
        if (!pv_r) begin
          prefix_r <= lzw_pkg::CODE_W'(in_ch.data_byte);
          pv_r     <= 1'b1;
        end else begin
          issuing_r <= (nfc_r != NFC_START);
        end
      end
      if (state_r == lzw_pkg::ST_SCAN) begin
        if (issuing_r) begin
          row_r <= ROW_W'(row_r + 1'b1);
          if (row_r == last_row_r) begin
            issuing_r <= 1'b0;
          end
        end
        if (tok[NUM_CELLS].active && tok[NUM_CELLS].hit) begin
          hit_r      <= 1'b1;
          hit_code_r <= tok[NUM_CELLS].code;
        end
        if (scan_done && found) begin
          prefix_r <= tok[NUM_CELLS].hit ? tok[NUM_CELLS].code : hit_code_r;
        end
      end
      if (load_miss) begin
        if (nfc_r < NFC_LIMIT) begin
          nfc_r <= nfc_r + lzw_pkg::NFC_W'(1);
        end
        prefix_r <= lzw_pkg::CODE_W'(byte_r);
      end
      if (load_flush) begin
        nfc_r    <= NFC_START;
        prefix_r <= '0;
        pv_r     <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_miss || load_flush) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_miss) begin
      out_code_r <= prefix_r;
      out_last_r <= 1'b0;
    end else if (load_flush) begin
      out_code_r <= prefix_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.code      = out_code_r;
  assign out_ch.last_code = out_last_r;

  // The free-code counter never leaves its legal range.
  a_nfc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nfc_r >= NFC_START) && (nfc_r <= NFC_LIMIT))
    else $error("next free code out of range");

  // Tokens only leave the cell row while a lookup is in progress.
  a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok[NUM_CELLS].active |-> (state_r == lzw_pkg::ST_SCAN))
    else $error("search token outside a lookup");

  // A lookup only runs with a pending prefix.
  a_scan_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzw_pkg::ST_SCAN) |-> pv_r)
    else $error("lookup without a prefix");

  // A flush restarts the stream.
  a_flush_restart: assert property (@(posedge clk) disable iff (!rst_n)
    load_flush |=> (!pv_r && (nfc_r == NFC_START) && out_valid_r && out_last_r))
    else $error("flush did not restart the stream");

endmodule

`default_nettype wire
